FILE: rtl/pswt_pkg.sv
// Shared types and constants for the priority schedule wait-time block.
`default_nettype none

package pswt_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int START_W = 20;
    localparam int WAIT_W  = 20;
    localparam int TAT_W   = 21;
    localparam int SUM_W   = 25;

    localparam int REC_W   = ARR_W + BURST_W + PRIO_W;
    localparam int IN_W    = ((REC_W + 7) / 8) * 8;
    localparam int RES_W   = REC_W + WAIT_W + TAT_W + 2 * SUM_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
    } t_rec;

    typedef struct packed {
        logic [SUM_W-1:0]   total_turnaround;
        logic [SUM_W-1:0]   total_wait;
        logic [TAT_W-1:0]   turnaround_ticks;
        logic [WAIT_W-1:0]  wait_ticks;
        t_rec               rec;
    } t_res;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_RI    = 7'b0000010,
        S_RJ    = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_WRI   = 7'b0010000,
        S_ERD   = 7'b0100000,
        S_ECALC = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/priority_schedule_wait_times.sv
// Top level: loads process records, exchange-sorts them by priority, emits wait times.
// Records load at one beat per cycle while the block is in its load state. After the closing
// beat, each outer sort pass reads record i and the next, compares along the rest of the set and
// writes record i back. Results then leave one at a time (RAM read, then compute into the output
// register). The next set loads while the final result still waits in the output register.
// Reset (synchronous, active low) empties the record count and sums; record RAM is not cleared.
`default_nettype none

module priority_schedule_wait_times #(
    parameter int MAX_PROCS = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // arrival[15:0], burst[31:16], prio[39:32]
    input  wire [pswt_pkg::IN_W-1:0]  s_axis_tdata,
    input  wire                       s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // out_arrival[15:0], out_burst[31:16], out_prio[39:32], wait_ticks[59:40],
    // turnaround_ticks[80:60], total_wait[105:81], total_turnaround[130:106]
    output logic [pswt_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCS);

    pswt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    pswt_pkg::t_rec r_cur, n_cur;
    logic [pswt_pkg::START_W-1:0] r_start, n_start;
    logic [pswt_pkg::SUM_W-1:0] r_wsum, n_wsum;
    logic [pswt_pkg::SUM_W-1:0] r_tsum, n_tsum;
    pswt_pkg::t_res r_res, n_res;
    logic r_ovalid, n_ovalid;
    logic r_olast, n_olast;

    logic ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    pswt_pkg::t_rec ram_wdata;
    logic [pswt_pkg::REC_W-1:0] ram_rdata;

    pswt_pkg::t_rec rec_in, rd_rec;
    logic in_acc, out_free, k_last;
    logic [CW-1:0] cnt_inc, i_p1, j_p1, k_p1;
    logic [pswt_pkg::WAIT_W-1:0] wait_v;
    logic [pswt_pkg::TAT_W-1:0] tat_v;
    logic [pswt_pkg::SUM_W-1:0] wsum_v, tsum_v;

    pswt_ram #(
        .WIDTH(pswt_pkg::REC_W),
        .DEPTH(MAX_PROCS)
    ) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign s_axis_tready = (r_state == pswt_pkg::S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {(pswt_pkg::OUT_W - pswt_pkg::RES_W)'(0), r_res};

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign rec_in   = pswt_pkg::t_rec'(s_axis_tdata[pswt_pkg::REC_W-1:0]);
    assign rd_rec   = pswt_pkg::t_rec'(ram_rdata);
    assign cnt_inc  = (r_cnt < MAX_CNT) ? r_cnt + CW'(1) : r_cnt;
    assign i_p1     = r_i + CW'(1);
    assign j_p1     = r_j + CW'(1);
    assign k_p1     = r_k + CW'(1);
    assign k_last   = (k_p1 == r_cnt);

    // wait = max(0, start - arrival); turnaround = wait + burst
    assign wait_v = (r_start > pswt_pkg::START_W'(rd_rec.arrival))
                  ? r_start - pswt_pkg::START_W'(rd_rec.arrival) : '0;
    assign tat_v  = pswt_pkg::TAT_W'(wait_v) + pswt_pkg::TAT_W'(rd_rec.burst);
    assign wsum_v = r_wsum + pswt_pkg::SUM_W'(wait_v);
    assign tsum_v = r_tsum + pswt_pkg::SUM_W'(tat_v);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_cur     = r_cur;
        n_start   = r_start;
        n_wsum    = r_wsum;
        n_tsum    = r_tsum;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_cnt[IW-1:0];
        ram_wdata = rec_in;
        ram_raddr = r_k[IW-1:0];
        case (r_state)
            pswt_pkg::S_LOAD: begin
                if (in_acc) begin
                    ram_we = (r_cnt < MAX_CNT);
                    n_cnt  = cnt_inc;
                    if (s_axis_tlast) begin
                        n_i = '0;
                        n_k = '0;
                        n_state = (cnt_inc == CW'(1)) ? pswt_pkg::S_ERD : pswt_pkg::S_RI;
                    end
                end
            end
            pswt_pkg::S_RI: begin
                ram_raddr = r_i[IW-1:0];
                n_state   = pswt_pkg::S_RJ;
            end
            pswt_pkg::S_RJ: begin
                n_cur     = rd_rec;
                n_j       = i_p1;
                ram_raddr = i_p1[IW-1:0];
                n_state   = pswt_pkg::S_CMP;
            end
            pswt_pkg::S_CMP: begin
                ram_raddr = j_p1[IW-1:0];
                if (r_cur.prio > rd_rec.prio) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[IW-1:0];
                    ram_wdata = r_cur;
                    n_cur     = rd_rec;
                end
                n_j = j_p1;
                if (j_p1 == r_cnt) begin
                    n_state = pswt_pkg::S_WRI;
                end
            end
            pswt_pkg::S_WRI: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IW-1:0];
                ram_wdata = r_cur;
                n_i       = i_p1;
                if (r_i + CW'(2) == r_cnt) begin
                    n_k     = '0;
                    n_state = pswt_pkg::S_ERD;
                end else begin
                    n_state = pswt_pkg::S_RI;
                end
            end
            pswt_pkg::S_ERD: begin
                n_state = pswt_pkg::S_ECALC;
            end
            pswt_pkg::S_ECALC: begin
                if (out_free) begin
                    n_ovalid                 = 1'b1;
                    n_olast                  = k_last;
                    n_res.rec                = rd_rec;
                    n_res.wait_ticks         = wait_v;
                    n_res.turnaround_ticks   = tat_v;
                    n_res.total_wait         = k_last ? wsum_v : '0;
                    n_res.total_turnaround   = k_last ? tsum_v : '0;
                    if (k_last) begin
                        n_cnt   = '0;
                        n_start = '0;
                        n_wsum  = '0;
                        n_tsum  = '0;
                        n_state = pswt_pkg::S_LOAD;
                    end else begin
                        n_start = r_start + pswt_pkg::START_W'(rd_rec.burst);
                        n_wsum  = wsum_v;
                        n_tsum  = tsum_v;
                        n_k     = k_p1;
                        n_state = pswt_pkg::S_ERD;
                    end
                end
            end
            default: begin
                n_state = pswt_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pswt_pkg::S_LOAD;
            r_cnt    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_start  <= '0;
            r_wsum   <= '0;
            r_tsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_start  <= n_start;
            r_wsum   <= n_wsum;
            r_tsum   <= n_tsum;
            r_ovalid <= n_ovalid;
        end
        r_cur   <= n_cur;
        r_res   <= n_res;
        r_olast <= n_olast;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("record count above store depth");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pswt_pkg::S_CMP) |-> (r_j > r_i && r_j < r_cnt))
        else $error("inner sort index out of range");

    a_hold_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pswt_pkg::S_ECALC && r_ovalid && !m_axis_tready)
        |=> (r_state == pswt_pkg::S_ECALC))
        else $error("result computed while output register full");

    a_last_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pswt_pkg::S_ECALC && out_free && k_last)
        |=> (r_state == pswt_pkg::S_LOAD && r_cnt == '0 && m_axis_tvalid && m_axis_tlast))
        else $error("set not closed after final result");

    a_totals_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast)
        |-> (r_res.total_wait == '0 && r_res.total_turnaround == '0))
        else $error("totals nonzero on a non-final result");

endmodule

`default_nettype wire

FILE: rtl/pswt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pswt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: verif/schedule_checker.sv
// Checker for the priority scheduler: predicts per-process waits from input beats and compares.
module schedule_checker
    import pswt_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_ready,
    input  wire [IN_W-1:0]   i_in_data,
    input  wire              i_in_last,
    input  wire              i_out_valid,
    input  wire              i_out_ready,
    input  wire [OUT_W-1:0]  i_out_data,
    input  wire              i_out_last,
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct packed {
        t_res res;
        logic last;
    } t_sched_beat;

    t_rec        held_recs [MAX_PROCS];
    int          held_n = 0;
    t_sched_beat sched_q [$];
    int          mismatches = 0;

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            note_mismatch($sformatf("%s expected %0d actual %0d", name, exp_v, act_v));
        end
    endtask

    // exchange sort on priority, then run back to back from time zero
    task automatic schedule_set();
        t_rec              recs [MAX_PROCS];
        t_rec              tmp;
        t_sched_beat       beat;
        int                n;
        logic [START_W-1:0] start;
        logic [WAIT_W-1:0] wait_v;
        logic [TAT_W-1:0]  tat_v;
        logic [SUM_W-1:0]  wait_acc;
        logic [SUM_W-1:0]  tat_acc;
        n = held_n;
        for (int k = 0; k < n; k++) recs[k] = held_recs[k];
        for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (recs[i].prio > recs[j].prio) begin
                    tmp     = recs[i];
                    recs[i] = recs[j];
                    recs[j] = tmp;
                end
            end
        end
        start    = '0;
        wait_acc = '0;
        tat_acc  = '0;
        for (int k = 0; k < n; k++) begin
            wait_v   = (start > START_W'(recs[k].arrival)) ?
                       WAIT_W'(start - START_W'(recs[k].arrival)) : '0;
            tat_v    = TAT_W'(wait_v) + TAT_W'(recs[k].burst);
            wait_acc = wait_acc + SUM_W'(wait_v);
            tat_acc  = tat_acc + SUM_W'(tat_v);
            beat.res.rec              = recs[k];
            beat.res.wait_ticks       = wait_v;
            beat.res.turnaround_ticks = tat_v;
            beat.last                 = (k == n - 1);
            beat.res.total_wait       = beat.last ? wait_acc : '0;
            beat.res.total_turnaround = beat.last ? tat_acc : '0;
            sched_q.push_back(beat);
            start = start + START_W'(recs[k].burst);
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_beat exp_b;
        t_res        got;
        t_rec        rec_in;
        if (!i_rst_n) begin
            held_n = 0;
            sched_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_res'(i_out_data[RES_W-1:0]);
                if (sched_q.size() == 0) begin
                    note_mismatch("result beat with nothing expected");
                end else begin
                    exp_b = sched_q.pop_front();
                    check_field("out_arrival", 32'(exp_b.res.rec.arrival),
                                32'(got.rec.arrival));
                    check_field("out_burst", 32'(exp_b.res.rec.burst), 32'(got.rec.burst));
                    check_field("out_prio", 32'(exp_b.res.rec.prio), 32'(got.rec.prio));
                    check_field("wait_ticks", 32'(exp_b.res.wait_ticks),
                                32'(got.wait_ticks));
                    check_field("turnaround_ticks", 32'(exp_b.res.turnaround_ticks),
                                32'(got.turnaround_ticks));
                    check_field("total_wait", 32'(exp_b.res.total_wait),
                                32'(got.total_wait));
                    check_field("total_turnaround", 32'(exp_b.res.total_turnaround),
                                32'(got.total_turnaround));
                    check_field("last_result", 32'(exp_b.last), 32'(i_out_last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                rec_in = t_rec'(i_in_data[REC_W-1:0]);
                if (held_n < MAX_PROCS) begin
                    held_recs[held_n] = rec_in;
                    held_n++;
                end
                if (i_in_last) begin
                    schedule_set();
                    held_n = 0;
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= sched_q.size();
    end

endmodule

FILE: verif/tb_priority_schedule_wait_times.sv
// Testbench top for the priority scheduler: clock, reset, stimulus, receiver stalls and verdict.
module tb_priority_schedule_wait_times;
    import pswt_pkg::*;

    localparam int MAX_PROCS      = 16;
    localparam int RANDOM_ITEMS   = 410;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_DRAIN      = 64;

    typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_STALLS} t_rx_mode;
    typedef enum logic [1:0] {SHAPE_FULL, SHAPE_TIGHT, SHAPE_TIES, SHAPE_WIDE} t_shape;

    logic             clk     = 1'b0;
    logic             rst_n   = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data  = '0;
    logic             s_last  = 1'b0;
    logic             m_ready = 1'b0;
    wire              s_ready;
    wire              m_valid;
    wire [OUT_W-1:0]  m_data;
    wire              m_last;
    int               mismatches;
    int               pending;

    int       burst_left  = 0;
    bit       no_gaps     = 1'b0;
    int       items_sent  = 0;
    int       idle_cycles = 0;
    t_rx_mode rx_mode     = RX_FREE;
    int       rx_phase_left = 0;
    int       rx_stall_left = 0;

    priority_schedule_wait_times #(.MAX_PROCS(MAX_PROCS)) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    schedule_checker #(.MAX_PROCS(MAX_PROCS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_last    (s_last),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_last   (m_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 2));
            rx_phase_left <= $urandom_range(50, 400);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_FREE: begin
                m_ready <= 1'b1;
            end
            RX_CHOPPY: begin
                m_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                if (rx_stall_left > 0) begin
                    m_ready       <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end else if ($urandom_range(0, 5) == 0) begin
                    m_ready       <= 1'b0;
                    rx_stall_left <= $urandom_range(3, 24);
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("priority_schedule_wait_times test failed");
            $finish;
        end
    end

    task automatic send_rec(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur,
                            input logic [PRIO_W-1:0] pri, input logic last);
        int   gap;
        t_rec rec;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                s_valid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
        end
        rec.arrival = arr;
        rec.burst   = bur;
        rec.prio    = pri;
        s_valid <= 1'b1;
        s_data  <= IN_W'(rec);
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_random_set(input int n_recs, input t_shape shape);
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bur;
        logic [PRIO_W-1:0]  pri;
        for (int k = 0; k < n_recs; k++) begin
            case (shape)
                SHAPE_TIGHT: begin
                    arr = ARR_W'($urandom_range(0, 2000));
                    bur = BURST_W'($urandom_range(0, 300));
                    pri = PRIO_W'($urandom);
                end
                SHAPE_TIES: begin
                    arr = ARR_W'($urandom_range(0, 1500));
                    bur = BURST_W'($urandom_range(0, 400));
                    pri = PRIO_W'($urandom_range(0, 2));
                end
                SHAPE_WIDE: begin
                    arr = ARR_W'($urandom);
                    bur = BURST_W'($urandom_range(40000, 65535));
                    pri = PRIO_W'($urandom);
                end
                default: begin
                    arr = ARR_W'($urandom);
                    bur = BURST_W'($urandom);
                    pri = PRIO_W'($urandom);
                end
            endcase
            send_rec(arr, bur, pri, k == n_recs - 1);
        end
    endtask

    initial begin
        int pick;
        int n_recs;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone records at both extremes, then a pair of extreme records
        send_rec(16'd0, 16'd0, 8'd0, 1'b1);
        send_rec(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_rec(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        send_rec(16'd0, 16'hFFFF, 8'd0, 1'b1);
        // equal priorities reordered by the exchange sort
        send_rec(16'd10, 16'd100, 8'd5, 1'b0);
        send_rec(16'd0, 16'd50, 8'd3, 1'b0);
        send_rec(16'd20, 16'd70, 8'd5, 1'b0);
        send_rec(16'd5, 16'd30, 8'd3, 1'b1);
        // full store, closing mark lands on a dropped record
        for (int k = 0; k < MAX_PROCS; k++) begin
            send_rec(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 500)),
                     8'($urandom_range(0, 255)), 1'b0);
        end
        send_rec(16'hFFFF, 16'hFFFF, 8'd0, 1'b1);

        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) n_recs = MAX_PROCS;
            else if (pick == 1) n_recs = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
            else if (pick == 2) n_recs = 1;
            else n_recs = $urandom_range(2, 10);
            send_random_set(n_recs, t_shape'($urandom_range(0, 3)));
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("priority_schedule_wait_times test passed");
        end else begin
            $display("priority_schedule_wait_times test failed");
        end
        $finish;
    end

endmodule
